// File: rtl/core/vcf_pkg.sv
// vcf_pkg: shared types and constants of the valid-mode convolution FIR.
// No dependencies; used by the tap cells, the top level and the checker.
package vcf_pkg;

    // Fixed field widths
    localparam int COEF_BITS  = 16;
    localparam int CONV_BITS  = 36;
    localparam int KLEN_BITS  = 5;
    localparam int INDEX_BITS = 4;

    // Request kinds
    localparam logic REQ_COEF   = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_HOLD
    } t_state;

    // Control broadcast to every tap cell
    typedef struct packed {
        logic                          shift;
        logic                          clear;
        logic                          coef_wr;
        logic [INDEX_BITS-1:0]         coef_index;
        logic signed [COEF_BITS-1:0]   coef_value;
    } t_cell_ctl;

endpackage

// File: rtl/core/vcf_tap_cell.sv
// vcf_tap_cell: one tap of the chain; holds a coefficient and a history sample,
// and adds its product to the partial sum passing through. Depends on vcf_pkg.
module vcf_tap_cell #(
    parameter int IDX         = 0,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  vcf_pkg::t_cell_ctl                   i_ctl,
    input  logic [vcf_pkg::KLEN_BITS-1:0]        i_klen,
    input  logic signed [SAMPLE_BITS-1:0]        i_hist,
    output logic signed [SAMPLE_BITS-1:0]        o_hist,
    input  logic                                 i_tok,
    output logic                                 o_tok,
    input  logic [vcf_pkg::CONV_BITS-1:0]        i_psum,
    output logic [vcf_pkg::CONV_BITS-1:0]        o_psum
);

    localparam int PROD_W = vcf_pkg::COEF_BITS + SAMPLE_BITS;
    localparam int EXT_W  = (PROD_W > vcf_pkg::CONV_BITS) ? PROD_W : vcf_pkg::CONV_BITS;

    logic signed [vcf_pkg::COEF_BITS-1:0] r_coef;
    logic signed [SAMPLE_BITS-1:0]        r_hist;
    logic                                 r_tok;
    logic [vcf_pkg::CONV_BITS-1:0]        r_psum;

    logic signed [PROD_W-1:0]             prod;
    logic signed [EXT_W-1:0]              prod_ext;
    logic [vcf_pkg::CONV_BITS-1:0]        term;
    logic                                 tap_on;
    logic                                 coef_hit;

    // Product of this tap, wrapped to the result width; zero beyond the kernel length
    always_comb begin
        prod     = r_coef * r_hist;
        prod_ext = EXT_W'(prod);
        tap_on   = int'(i_klen) > IDX;
        term     = tap_on ? prod_ext[vcf_pkg::CONV_BITS-1:0] : '0;
        coef_hit = i_ctl.coef_wr && (int'(i_ctl.coef_index) == IDX);
    end

    // Coefficient store, no reset
    always_ff @(posedge i_clk) begin
        if (coef_hit) begin
            r_coef <= i_ctl.coef_value;
        end
    end

    // History stage; frame start zeroes all but the newest
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist <= '0;
        end else if (i_ctl.shift) begin
            r_hist <= (i_ctl.clear && IDX != 0) ? '0 : i_hist;
        end
    end

    // Sum wave moves one cell per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= 1'b0;
        end else begin
            r_tok <= i_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tok) begin
            r_psum <= i_psum + term;
        end
    end

    assign o_hist = r_hist;
    assign o_tok  = r_tok;
    assign o_psum = r_psum;

endmodule

// File: rtl/core/valid_convolution_fir_unit.sv
// valid_convolution_fir_unit: top level of the valid-mode convolution FIR.
// Depends on vcf_pkg and vcf_tap_cell; vcf_checker binds to it.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+--------------------------------------
//  in      | input     | i_in_valid / o_in_stall| req_type, coef_index, coef_value,
//          |           |                        | sample, first_of_frame
//  out     | output    | o_out_valid/i_out_stall| conv_value
//  cfg     | input     | i_cfg_valid/o_cfg_ready| kernel_length (5 bits)
//
// A coefficient request writes the coefficient of one tap cell. A sample request
// shifts the history, launches the sum, and then moves through each tap cell as the
// partial sum walks down the chain. The result sits in an output register; a
// stalled output holds the chain at its end until taken. Reset is synchronous
// and clears history, fill count and control; coefficients are not cleared.
module valid_convolution_fir_unit #(
    parameter int MAX_TAPS    = 16,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // input requests
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic                                 i_req_type,
    input  logic [vcf_pkg::INDEX_BITS-1:0]       i_coef_index,
    input  logic signed [vcf_pkg::COEF_BITS-1:0] i_coef_value,
    input  logic signed [SAMPLE_BITS-1:0]        i_sample,
    input  logic                                 i_first_of_frame,
    // results
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [vcf_pkg::CONV_BITS-1:0] o_conv_value,
    // configuration
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [vcf_pkg::KLEN_BITS-1:0]        i_cfg_data
);

    localparam int FILL_W = $clog2(MAX_TAPS + 1);

    vcf_pkg::t_state                  r_state, n_state;
    logic [vcf_pkg::KLEN_BITS-1:0]    r_klen, n_klen;
    logic [FILL_W-1:0]                r_fill, n_fill;
    logic                             r_emit;
    logic                             r_launch;
    logic                             r_out_valid;
    logic [vcf_pkg::CONV_BITS-1:0]    r_conv;

    logic                             in_acc;
    logic                             sample_acc;
    logic                             out_free;
    logic                             load_out;
    vcf_pkg::t_cell_ctl               cell_ctl;

    logic signed [SAMPLE_BITS-1:0]    hist_chain [MAX_TAPS+1];
    logic                             tok_chain  [MAX_TAPS+1];
    logic [vcf_pkg::CONV_BITS-1:0]    psum_chain [MAX_TAPS+1];

    assign in_acc     = i_in_valid && !o_in_stall;
    assign sample_acc = in_acc && (i_req_type == vcf_pkg::REQ_SAMPLE);
    assign out_free   = !r_out_valid || !i_out_stall;

    // Broadcast control to the cells
    always_comb begin
        cell_ctl.shift      = sample_acc;
        cell_ctl.clear      = i_first_of_frame;
        cell_ctl.coef_wr    = in_acc && (i_req_type == vcf_pkg::REQ_COEF);
        cell_ctl.coef_index = i_coef_index;
        cell_ctl.coef_value = i_coef_value;
    end

    // Tap chain
    assign hist_chain[0] = i_sample;
    assign tok_chain[0]  = r_launch;
    assign psum_chain[0] = '0;

    for (genvar g = 0; g < MAX_TAPS; g++) begin : g_tap
        vcf_tap_cell #(
            .IDX        (g),
            .SAMPLE_BITS(SAMPLE_BITS)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_ctl  (cell_ctl),
            .i_klen (r_klen),
            .i_hist (hist_chain[g]),
            .o_hist (hist_chain[g+1]),
            .i_tok  (tok_chain[g]),
            .o_tok  (tok_chain[g+1]),
            .i_psum (psum_chain[g]),
            .o_psum (psum_chain[g+1])
        );
    end

    // Kernel length register, clamped on write
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_klen = i_cfg_data;
        if (i_cfg_data == '0) begin
            n_klen = vcf_pkg::KLEN_BITS'(1);
        end else if (int'(i_cfg_data) > MAX_TAPS) begin
            n_klen = vcf_pkg::KLEN_BITS'(MAX_TAPS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_klen <= vcf_pkg::KLEN_BITS'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_klen <= n_klen;
        end
    end

    // Frame fill count, saturating
    always_comb begin
        if (i_first_of_frame) begin
            n_fill = FILL_W'(1);
        end else if (int'(r_fill) < MAX_TAPS) begin
            n_fill = r_fill + FILL_W'(1);
        end else begin
            n_fill = r_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_emit   <= 1'b0;
            r_launch <= 1'b0;
        end else begin
            r_launch <= sample_acc;
            if (sample_acc) begin
                r_fill <= n_fill;
                r_emit <= int'(n_fill) >= int'(r_klen);
            end
        end
    end

    // Sequencer: next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            vcf_pkg::ST_IDLE: begin
                if (sample_acc) n_state = vcf_pkg::ST_RUN;
            end
            vcf_pkg::ST_RUN: begin
                if (tok_chain[MAX_TAPS]) begin
                    if (!r_emit || out_free) n_state = vcf_pkg::ST_IDLE;
                    else                     n_state = vcf_pkg::ST_HOLD;
                end
            end
            vcf_pkg::ST_HOLD: begin
                if (out_free) n_state = vcf_pkg::ST_IDLE;
            end
            default: n_state = vcf_pkg::ST_IDLE;
        endcase
    end

    // Sequencer: outputs
    always_comb begin
        o_in_stall = 1'b1;
        load_out   = 1'b0;
        unique case (r_state)
            vcf_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
            end
            vcf_pkg::ST_RUN: begin
                load_out = tok_chain[MAX_TAPS] && r_emit && out_free;
            end
            vcf_pkg::ST_HOLD: begin
                load_out = out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vcf_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_conv <= psum_chain[MAX_TAPS];
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_conv_value = r_conv;

endmodule

// File: rtl/core/vcf_checker.sv
// vcf_checker: port-level assertions for valid_convolution_fir_unit.
// Depends on vcf_pkg; bound to the top level at the end of this file.
module vcf_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_in_valid,
    input logic                                 o_in_stall,
    input logic                                 i_req_type,
    input logic signed [SAMPLE_BITS-1:0]        i_sample,
    input logic                                 o_out_valid,
    input logic                                 i_out_stall,
    input logic signed [vcf_pkg::CONV_BITS-1:0] o_conv_value
);

    logic coef_acc;
    logic samp_acc;

    assign coef_acc = i_in_valid && !o_in_stall && (i_req_type == vcf_pkg::REQ_COEF);
    assign samp_acc = i_in_valid && !o_in_stall && (i_req_type == vcf_pkg::REQ_SAMPLE);

    // A stalled result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_conv_value))
        else $error("stalled result changed");

    // A sample request keeps the block busy while its sum runs down the chain
    a_busy_after_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        samp_acc |=> o_in_stall)
        else $error("input not stalled after sample request");

    // A coefficient request never produces a result
    a_coef_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        coef_acc |=> !$rose(o_out_valid))
        else $error("result appeared after coefficient request");

    // A result cannot come the cycle right after a sample is taken
    a_sample_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        samp_acc |=> !$rose(o_out_valid))
        else $error("result too early after sample request");

    // Sample payload is used here only to check that it is known when taken
    a_sample_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        samp_acc |-> !$isunknown(i_sample))
        else $error("sample request with unknown sample");

endmodule

bind valid_convolution_fir_unit vcf_checker #(
    .SAMPLE_BITS(SAMPLE_BITS)
) u_vcf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_req_type  (i_req_type),
    .i_sample    (i_sample),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_conv_value(o_conv_value)
);
